/* design/rtt_pkg.sv */
package rtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int SEQ_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 8;
  localparam int TIME_W   = 32;
  localparam int IVL_W    = 16;
  localparam int KIND_W   = 3;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_ACKED   = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_RESEND  = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT   = 8'd1;

  localparam logic [IVL_W-1:0]   RESET_INTERVAL = 16'd100;
  localparam logic [COUNT_W-1:0] RESET_LIMIT    = 8'd5;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
    logic [TIME_W-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

/* design/rtt_intf.sv */
interface rtt_in_if;
  logic                           valid;
  logic                           ready;
  logic [rtt_pkg::CMD_W-1:0]      command;
  logic [rtt_pkg::SEQ_W-1:0]      seq_number;
  logic [rtt_pkg::HANDLE_W-1:0]   buffer_handle;
  logic [rtt_pkg::TIME_W-1:0]     now_time;

  modport source (output valid, command, seq_number, buffer_handle, now_time, input ready);
  modport sink   (input valid, command, seq_number, buffer_handle, now_time, output ready);
endinterface

interface rtt_out_if;
  logic                           valid;
  logic                           ready;
  logic [rtt_pkg::KIND_W-1:0]     kind;
  logic [rtt_pkg::SEQ_W-1:0]      out_seq;
  logic [rtt_pkg::HANDLE_W-1:0]   out_handle;
  logic [rtt_pkg::COUNT_W-1:0]    attempt;
  logic                           last;

  modport source (output valid, kind, out_seq, out_handle, attempt, last, input ready);
  modport sink   (input valid, kind, out_seq, out_handle, attempt, last, output ready);
endinterface

interface rtt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtt_pkg::CFG_IDX_W-1:0]   index;
  logic [rtt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/rtt_mem.sv */
module rtt_mem (
  input  logic              clk,
  input  rtt_pkg::mem_req_t req,
  output rtt_pkg::entry_t   rd_data
);
  import rtt_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/rtt_ctrl.sv */
module rtt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  rtt_in_if.sink                        in_ch,
  rtt_out_if.source                     out_ch,
  input  logic [rtt_pkg::IVL_W-1:0]     resend_interval,
  input  logic [rtt_pkg::COUNT_W-1:0]   attempt_limit,
  output rtt_pkg::mem_req_t             mem_req,
  input  rtt_pkg::entry_t               rd_data
);
  import rtt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;

  logic [CNT_W-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic                ev_v_r, ev_v_nxt;
  logic [IDX_W-1:0]    ev_idx_r, ev_idx_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;

  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [HANDLE_W-1:0] hit_handle_r, hit_handle_nxt;
  logic [COUNT_W-1:0]  hit_count_r, hit_count_nxt;
  logic                free_r, free_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [COUNT_W-1:0]  out_attempt_r, out_attempt_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                out_load;
  logic                ev_valid_bit;
  logic [TIME_W-1:0]   age;
  logic                due;
  logic                expired;
  logic                need_emit;
  logic                advance;
  logic                issue_more;
  logic [COUNT_W-1:0]  count_inc;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign ev_valid_bit = valid_r[ev_idx_r];
  assign age          = now_r - rd_data.stamp;
  assign due          = ev_valid_bit && (age >= TIME_W'(resend_interval));
  assign expired      = rd_data.count >= attempt_limit;
  assign count_inc    = rd_data.count + COUNT_W'(1);
  assign need_emit    = ev_v_r && (cmd_r == CMD_TICK) && due && !expired;
  assign advance      = !(need_emit && !out_free);
  assign issue_more   = iss_cnt_r < CNT_W'(TABLE_DEPTH);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    seq_nxt         = seq_r;
    handle_nxt      = handle_r;
    now_nxt         = now_r;
    iss_cnt_nxt     = iss_cnt_r;
    ev_v_nxt        = ev_v_r;
    ev_idx_nxt      = ev_idx_r;
    valid_nxt       = valid_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_handle_nxt  = hit_handle_r;
    hit_count_nxt   = hit_count_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    out_load        = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_seq_nxt     = out_seq_r;
    out_handle_nxt  = out_handle_r;
    out_attempt_nxt = out_attempt_r;
    out_last_nxt    = out_last_r;
    mem_req         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt     = in_ch.command;
          seq_nxt     = in_ch.seq_number;
          handle_nxt  = in_ch.buffer_handle;
          now_nxt     = in_ch.now_time;
          iss_cnt_nxt = '0;
          ev_v_nxt    = 1'b0;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          if (in_ch.command inside {CMD_ADD, CMD_ACK, CMD_TICK}) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (advance) begin
          ev_v_nxt = issue_more;
          if (issue_more) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = iss_cnt_r[IDX_W-1:0];
            ev_idx_nxt      = iss_cnt_r[IDX_W-1:0];
            iss_cnt_nxt     = iss_cnt_r + CNT_W'(1);
          end
        end
        if (ev_v_r && advance) begin
          if (cmd_r == CMD_TICK) begin
            if (due) begin
              if (expired) begin
                valid_nxt[ev_idx_r] = 1'b0;
              end else begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = ev_idx_r;
                mem_req.wr_data       = rd_data;
                mem_req.wr_data.count = count_inc;
                mem_req.wr_data.stamp = now_r;
                out_load        = 1'b1;
                out_kind_nxt    = KIND_RESEND;
                out_seq_nxt     = rd_data.seq;
                out_handle_nxt  = rd_data.handle;
                out_attempt_nxt = count_inc;
                out_last_nxt    = 1'b0;
              end
            end
          end else begin
            if (ev_valid_bit && (rd_data.seq == seq_r) && !hit_r) begin
              hit_nxt        = 1'b1;
              hit_idx_nxt    = ev_idx_r;
              hit_handle_nxt = rd_data.handle;
              hit_count_nxt  = rd_data.count;
            end
            if (!ev_valid_bit && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = ev_idx_r;
            end
          end
        end
        if (!issue_more && !ev_v_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
          case (cmd_r)
            CMD_ADD: begin
              out_seq_nxt     = seq_r;
              out_handle_nxt  = handle_r;
              out_attempt_nxt = '0;
              if (hit_r || free_r) begin
                mem_req.wr_en          = 1'b1;
                mem_req.wr_addr        = hit_r ? hit_idx_r : free_idx_r;
                mem_req.wr_data.seq    = seq_r;
                mem_req.wr_data.handle = handle_r;
                mem_req.wr_data.count  = '0;
                mem_req.wr_data.stamp  = now_r;
                valid_nxt[mem_req.wr_addr] = 1'b1;
                out_kind_nxt = KIND_ADDED;
              end else begin
                out_kind_nxt = KIND_FULL;
              end
            end
            CMD_ACK: begin
              out_seq_nxt = seq_r;
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                out_kind_nxt    = KIND_ACKED;
                out_handle_nxt  = hit_handle_r;
                out_attempt_nxt = hit_count_r;
              end else begin
                out_kind_nxt    = KIND_UNKNOWN;
                out_handle_nxt  = '0;
                out_attempt_nxt = '0;
              end
            end
            default: begin
              out_kind_nxt    = KIND_DONE;
              out_seq_nxt     = '0;
              out_handle_nxt  = '0;
              out_attempt_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_cnt_r   <= '0;
      ev_v_r      <= 1'b0;
      valid_r     <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      ev_v_r      <= ev_v_nxt;
      valid_r     <= valid_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    seq_r         <= seq_nxt;
    handle_r      <= handle_nxt;
    now_r         <= now_nxt;
    ev_idx_r      <= ev_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_handle_r  <= hit_handle_nxt;
    hit_count_r   <= hit_count_nxt;
    free_idx_r    <= free_idx_nxt;
    out_kind_r    <= out_kind_nxt;
    out_seq_r     <= out_seq_nxt;
    out_handle_r  <= out_handle_nxt;
    out_attempt_r <= out_attempt_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.out_seq    = out_seq_r;
  assign out_ch.out_handle = out_handle_r;
  assign out_ch.attempt    = out_attempt_r;
  assign out_ch.last       = out_last_r;

  a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("Read and write hit the same slot in one cycle.");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_v_r |-> (state_r == ST_SCAN))
    else $error("Evaluation stage is busy outside the scan.");

  a_finish_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (!ev_v_r && (iss_cnt_r == CNT_W'(TABLE_DEPTH))))
    else $error("Final result issued before every slot was visited.");

  a_finish_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("Final result was not presented.");

endmodule

/* design/retransmit_tracking_table.sv */
// Tracks unacknowledged packets in a table of TABLE_DEPTH slots.
// Items arrive on in_chan: add stores a sequence number and buffer handle,
// acknowledge removes the matching entry, and tick resends every entry whose
// age has reached the resend interval and whose attempt count is below the
// attempt limit, and drops a due entry that has reached the limit. Results
// leave on out_chan, one per add or acknowledge, and for a tick one resend
// item per resent entry followed by a done item; last marks the final result
// of each input item. cfg_chan writes the resend interval (index 0) and
// attempt limit (index 1); it is always ready and should only be used while
// the table is idle. Each item is handled in order: it is accepted, each
// slot's entry is read from the entry memory through its single read port,
// the last slot is evaluated, the scan is closed and the final result is
// issued. The next item is accepted as soon as the final result sits in the
// output register. When the receiver stalls, the scan pauses on a slot that
// must emit a resend until the output register frees up. Reset clears the
// valid bits and the output valid flag and sets an interval of 100 and a
// limit of 5; the entry memory itself is not cleared.
module retransmit_tracking_table (
  input  logic      clk,
  input  logic      rst_n,
  rtt_in_if.sink    in_chan,
  rtt_out_if.source out_chan,
  rtt_cfg_if.sink   cfg_chan
);
  import rtt_pkg::*;

  logic [IVL_W-1:0]   resend_interval_r;
  logic [COUNT_W-1:0] attempt_limit_r;
  mem_req_t           mem_req;
  entry_t             rd_data;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resend_interval_r <= RESET_INTERVAL;
      attempt_limit_r   <= RESET_LIMIT;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_RESEND_INTERVAL: resend_interval_r <= cfg_chan.data[IVL_W-1:0];
        CFG_ATTEMPT_LIMIT:   attempt_limit_r   <= cfg_chan.data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rtt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_chan),
    .out_ch          (out_chan),
    .resend_interval (resend_interval_r),
    .attempt_limit   (attempt_limit_r),
    .mem_req         (mem_req),
    .rd_data         (rd_data)
  );

  rtt_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
